[rtl/stencil_derivative_stream_core_defines.svh]
// Assertion macros shared by the stencil derivative checker
`ifndef STENCIL_DERIVATIVE_STREAM_CORE_DEFINES_SVH
`define STENCIL_DERIVATIVE_STREAM_CORE_DEFINES_SVH

// Check a consequence in the same cycle
`define SDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the following cycle
`define SDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sds_pkg.sv]
// Types and constants of the stencil derivative stream
package sds_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = 21;
    localparam int MAG_W    = 20;
    localparam int QUOT_W   = 19;
    localparam int STEP_W   = 16;
    localparam int DERIV_W  = 32;
    localparam int PROD1_W  = 40;
    localparam int QR_W     = 36;
    localparam int MR_W     = 17;
    localparam int TP_W     = 33;
    localparam int SUM_W    = 37;
    localparam int SEEN_W   = 3;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [MAG_W-1:0]  RECIP3_WIDE   = 20'hAAAAB;
    localparam int                RECIP3_W_SH   = 21;
    localparam logic [STEP_W-1:0] RECIP3_NARROW = 16'hAAAB;
    localparam int                RECIP3_N_SH   = 17;

    localparam logic [SUM_W-1:0]   MAG_NEG_LIMIT = 37'h0_8000_0000;
    localparam logic [SUM_W-1:0]   MAG_POS_LIMIT = 37'h0_7FFF_FFFF;
    localparam logic [DERIV_W-1:0] DERIV_MIN     = 32'h8000_0000;
    localparam logic [DERIV_W-1:0] DERIV_MAX     = 32'h7FFF_FFFF;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd256;
    localparam logic [SEEN_W-1:0] SEEN_MAX   = 3'd4;
    localparam logic [SEEN_W-1:0] SEEN_TWO   = 3'd2;
    localparam logic [SEEN_W-1:0] SEEN_THREE = 3'd3;

    typedef logic [1:0] t_kind;
    localparam t_kind DIV_ONE    = 2'd0;
    localparam t_kind DIV_TWO    = 2'd1;
    localparam t_kind DIV_TWELVE = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DIFF_W-1:0]   t_diff;

    typedef struct packed {
        t_diff diff;
        t_kind kind;
        logic  short_rec;
        logic  last;
    } t_desc;

endpackage

[rtl/stencil_derivative_stream_core.sv]
// Streaming derivative of a sample record: sample window, result queue, register port
// A sample is taken in every cycle while o_ready is high; each sample from
// the third on yields the derivative of the sample two places back, and the
// record's last sample queues the final three results (one or two zero
// results flagged short for a record of one or two samples), so the input
// holds off at the end of each record until a single queued result is left.
// The three-entry result queue feeds one result per cycle, when not stalled,
// into a five-stage scaling pipeline (multiply by the step reciprocal, exact
// divide by 2 or 12 through shifts and reciprocal multiplies by 3, saturate).
// Write step_reciprocal only while no record is in flight.
module stencil_derivative_stream_core import sds_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                      i_record_end,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [DERIV_W-1:0] o_derivative,
    output logic                      o_short_record,
    output logic                      o_last_result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    logic [STEP_W-1:0] r_step;
    t_sample           r_win [4];
    logic [SEEN_W-1:0] r_seen;
    t_desc             r_fd [3];
    logic [1:0]        r_fn;

    logic    accept;
    logic    emit;
    logic    s_ready;
    t_desc   lag;
    t_desc   n_fd [3];
    logic [1:0] n_fn;
    t_diff   c_x, w0_x, w1_x, w2_x, w3_x;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : {{(DATA_W-STEP_W){1'b0}}, r_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_step <= pwdata[STEP_W-1:0];
        end
    end

    assign accept  = i_valid && o_ready;
    assign emit    = (r_fn != 2'd0) && s_ready;
    assign o_ready = (r_fn == 2'd0) || ((r_fn == 2'd1) && s_ready);

    always_comb begin
        c_x  = {{(DIFF_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
        w0_x = {{(DIFF_W-SAMPLE_W){r_win[0][SAMPLE_W-1]}}, r_win[0]};
        w1_x = {{(DIFF_W-SAMPLE_W){r_win[1][SAMPLE_W-1]}}, r_win[1]};
        w2_x = {{(DIFF_W-SAMPLE_W){r_win[2][SAMPLE_W-1]}}, r_win[2]};
        w3_x = {{(DIFF_W-SAMPLE_W){r_win[3][SAMPLE_W-1]}}, r_win[3]};

        lag.short_rec = 1'b0;
        lag.last      = 1'b0;
        case (r_seen)
            SEEN_TWO: begin
                lag.diff = w0_x - w1_x;
                lag.kind = DIV_ONE;
            end
            SEEN_THREE: begin
                lag.diff = w0_x - w2_x;
                lag.kind = DIV_TWO;
            end
            default: begin
                lag.diff = ((w0_x - w2_x) <<< 3) - (c_x - w3_x);
                lag.kind = DIV_TWELVE;
            end
        endcase

        n_fd[0] = lag;
        n_fd[1] = '{diff: c_x - w1_x, kind: DIV_TWO, short_rec: 1'b0, last: 1'b0};
        n_fd[2] = '{diff: c_x - w0_x, kind: DIV_ONE, short_rec: 1'b0, last: 1'b1};
        n_fn    = 2'd0;

        if (r_seen < SEEN_TWO) begin
            n_fd[0] = '{diff: '0, kind: DIV_ONE, short_rec: 1'b1, last: (r_seen == '0)};
            n_fd[1] = '{diff: '0, kind: DIV_ONE, short_rec: 1'b1, last: 1'b1};
            n_fn    = i_record_end ? (r_seen[1:0] + 2'd1) : 2'd0;
        end else begin
            n_fn = i_record_end ? 2'd3 : 2'd1;
        end
    end

    // window and sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            for (int i = 0; i < 4; i++) r_win[i] <= '0;
        end else if (accept) begin
            if (i_record_end) begin
                r_seen <= '0;
                for (int i = 0; i < 4; i++) r_win[i] <= '0;
            end else begin
                if (r_seen < SEEN_MAX) r_seen <= r_seen + SEEN_W'(1);
                r_win[0] <= i_sample;
                r_win[1] <= r_win[0];
                r_win[2] <= r_win[1];
                r_win[3] <= r_win[2];
            end
        end
    end

    // pending result requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn <= 2'd0;
        end else if (accept) begin
            r_fn <= n_fn;
        end else if (emit) begin
            r_fn <= r_fn - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fd[0] <= n_fd[0];
            r_fd[1] <= n_fd[1];
            r_fd[2] <= n_fd[2];
        end else if (emit) begin
            r_fd[0] <= r_fd[1];
            r_fd[1] <= r_fd[2];
        end
    end

    sds_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (r_step),
        .i_valid        (r_fn != 2'd0),
        .o_ready        (s_ready),
        .i_desc         (r_fd[0]),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_derivative   (o_derivative),
        .o_short_record (o_short_record),
        .o_last_result  (o_last_result)
    );

endmodule

[rtl/sds_scale.sv]
// Scaling pipeline: difference times step reciprocal, exact divide, saturate
module sds_scale import sds_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [STEP_W-1:0]         i_step,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_desc                     i_desc,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [DERIV_W-1:0] o_derivative,
    output logic                      o_short_record,
    output logic                      o_last_result
);

    logic        r_v1, r_v2, r_v3, r_v4, r_ov;
    logic        rdy1, rdy2, rdy3, rdy4, rdy_o;

    t_desc       r_d1;

    logic [MAG_W-1:0]  r_a2;
    logic [QUOT_W-1:0] r_qd2;
    logic        r_neg2, r_short2, r_last2;
    t_kind       r_kind2;

    logic [MAG_W-1:0] r_q3;
    logic [1:0]  r_m3;
    logic        r_neg3, r_short3, r_last3;
    t_kind       r_kind3;

    logic [QR_W-1:0]   r_qr4;
    logic [STEP_W-1:0] r_t4;
    logic        r_neg4, r_short4, r_last4;
    t_kind       r_kind4;

    logic [DERIV_W-1:0] r_deriv;
    logic        r_short_o, r_last_o;

    logic              neg1;
    logic [DIFF_W-1:0] abs_full;
    logic [MAG_W-1:0]  a1;
    logic [PROD1_W-1:0] prod1;

    logic [MAG_W-1:0]  q2;
    logic [DIFF_W-1:0] three_q;
    logic [DIFF_W-1:0] m_full;
    logic [MAG_W-1:0]  n_q3;
    logic [1:0]        n_m3;

    logic [QR_W-1:0]  qr;
    logic [MR_W-1:0]  mr;
    logic [TP_W-1:0]  tp;

    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   mag;
    logic [DERIV_W-1:0] n_deriv;

    assign rdy_o   = !r_ov || i_ready;
    assign rdy4    = !r_v4 || rdy_o;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        neg1     = r_d1.diff[DIFF_W-1];
        abs_full = neg1 ? (~r_d1.diff + DIFF_W'(1)) : r_d1.diff;
        a1       = abs_full[MAG_W-1:0];
        prod1    = a1 * RECIP3_WIDE;
    end

    always_comb begin
        q2      = {1'b0, r_qd2};
        three_q = {q2, 1'b0} + {1'b0, q2};
        m_full  = {1'b0, r_a2} - three_q;
        case (r_kind2)
            DIV_TWELVE: begin
                n_q3 = q2;
                n_m3 = m_full[1:0];
            end
            default: begin
                n_q3 = r_a2;
                n_m3 = 2'd0;
            end
        endcase
    end

    always_comb begin
        qr = r_q3 * i_step;
        case (r_m3)
            2'd1:    mr = {1'b0, i_step};
            2'd2:    mr = {i_step, 1'b0};
            default: mr = '0;
        endcase
        tp = mr * RECIP3_NARROW;
    end

    always_comb begin
        sum = {1'b0, r_qr4} + {{(SUM_W-STEP_W){1'b0}}, r_t4};
        case (r_kind4)
            DIV_TWO:    mag = sum >> 1;
            DIV_TWELVE: mag = sum >> 2;
            default:    mag = sum;
        endcase
        if (r_neg4) begin
            n_deriv = (mag > MAG_NEG_LIMIT) ? DERIV_MIN : (~mag[DERIV_W-1:0] + DERIV_W'(1));
        end else begin
            n_deriv = (mag > MAG_POS_LIMIT) ? DERIV_MAX : mag[DERIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy_o) r_ov <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_d1 <= i_desc;
        end
        if (rdy2) begin
            r_a2     <= a1;
            r_qd2    <= prod1[PROD1_W-1:RECIP3_W_SH];
            r_neg2   <= neg1;
            r_kind2  <= r_d1.kind;
            r_short2 <= r_d1.short_rec;
            r_last2  <= r_d1.last;
        end
        if (rdy3) begin
            r_q3     <= n_q3;
            r_m3     <= n_m3;
            r_neg3   <= r_neg2;
            r_kind3  <= r_kind2;
            r_short3 <= r_short2;
            r_last3  <= r_last2;
        end
        if (rdy4) begin
            r_qr4    <= qr;
            r_t4     <= tp[TP_W-1:RECIP3_N_SH];
            r_neg4   <= r_neg3;
            r_kind4  <= r_kind3;
            r_short4 <= r_short3;
            r_last4  <= r_last3;
        end
        if (rdy_o) begin
            r_deriv   <= n_deriv;
            r_short_o <= r_short4;
            r_last_o  <= r_last4;
        end
    end

    assign o_valid        = r_ov;
    assign o_derivative   = r_deriv;
    assign o_short_record = r_short_o;
    assign o_last_result  = r_last_o;

endmodule

[rtl/sds_checker.sv]
// Port-level checks of the stencil derivative stream, bound to the top level
`include "stencil_derivative_stream_core_defines.svh"

module sds_checker import sds_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic signed [SAMPLE_W-1:0] i_sample,
    input logic                      i_record_end,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic signed [DERIV_W-1:0] o_derivative,
    input logic                      o_short_record,
    input logic                      o_last_result,
    input logic                      psel,
    input logic                      penable,
    input logic                      pwrite,
    input logic [ADDR_W-1:0]         paddr,
    input logic [DATA_W-1:0]         pwdata,
    input logic [DATA_W-1:0]         prdata,
    input logic                      pready
);

    `SDS_ASSERT_SAME(a_short_zero,
        o_valid && o_short_record, o_derivative == '0,
        "short record result not zero")
    `SDS_ASSERT_NEXT(a_out_hold,
        o_valid && !i_ready,
        o_valid && $stable(o_derivative) && $stable(o_last_result),
        "stalled result changed")
    `SDS_ASSERT_NEXT(a_in_hold,
        i_valid && !o_ready,
        i_valid && $stable(i_sample) && $stable(i_record_end),
        "waiting request changed")
    `SDS_ASSERT_NEXT(a_step_readback,
        psel && penable && pwrite && pready && !paddr[2],
        paddr[2] || (prdata[31:16] == 16'h0 && prdata[15:0] == $past(pwdata[15:0])),
        "step reciprocal readback mismatch")

endmodule

bind stencil_derivative_stream_core sds_checker u_sds_checker (.*);
